[sv/assert_macros.svh]
// Assertion helpers for the command parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a implies b at every clock edge outside reset
`define CHK_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("check failed");
// check that a implies b on the next clock edge
`define CHK_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("check failed");
`endif

[sv/scp_pkg.sv]
package scp_pkg;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_UNKNOWN = 4'd1;
  localparam logic [3:0] ST_BAD = 4'd2;
  localparam logic [3:0] ST_HEX = 4'd3;
  localparam logic [3:0] ST_DEC = 4'd4;
  localparam logic [3:0] ST_CFG = 4'd5;
  localparam logic [3:0] ST_INUM = 4'd6;
  localparam logic [3:0] ST_MIN = 4'd7;
  localparam logic [3:0] ST_SEC = 4'd8;
  localparam logic [3:0] ST_PREFIX = 4'd9;
  localparam logic [3:0] ST_PORT = 4'd10;
  localparam logic [3:0] ST_BIT = 4'd11;

  localparam logic [3:0] PH_NONE = 4'd0;
  localparam logic [3:0] PH_CFG_FIELD = 4'd1;
  localparam logic [3:0] PH_CFG_VALUE = 4'd2;
  localparam logic [3:0] PH_INUM = 4'd3;
  localparam logic [3:0] PH_PROG = 4'd4;
  localparam logic [3:0] PH_HOUR = 4'd5;
  localparam logic [3:0] PH_MIN = 4'd6;
  localparam logic [3:0] PH_SEC = 4'd7;
  localparam logic [3:0] PH_MSEC = 4'd8;
  localparam logic [3:0] PH_OPCODE = 4'd9;
  localparam logic [3:0] PH_PORT = 4'd10;
  localparam logic [3:0] PH_HEX = 4'd11;
  localparam logic [3:0] PH_BIT = 4'd12;
  localparam logic [3:0] PH_GBIT = 4'd13;

  localparam logic [4:0] CMD_SEL_PROG = 5'd3;
  localparam logic [4:0] CMD_TIME_A = 5'd9;
  localparam logic [4:0] CMD_TIME_B = 5'd10;
  localparam logic [4:0] CMD_DEL_INSTR = 5'd11;
  localparam logic [4:0] CMD_WR_CFG = 5'd18;

  localparam logic [6:0] TIME_LIMIT = 7'd60;

  // character class codes produced by the front end
  typedef enum logic [2:0] {
    CL_OTHER, CL_DASH, CL_COLON, CL_DEC, CL_HEXL, CL_PORT
  } char_class_t;

  // classified item passed from front to back
  typedef struct packed {
    logic        clr;
    logic [7:0]  ch;
    char_class_t cls;
    logic [3:0]  dig;
    logic [2:0]  port;
    logic [4:0]  cmd_code;
  } cls_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        done;
    logic [4:0]  command;
    logic [3:0]  phase;
    logic [7:0]  small_arg;
    logic [15:0] wide_arg;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  msec;
    logic [5:0]  instr_type;
    logic [7:0]  instr_arg;
  } result_t;

  // command letter to code, zero for unknown
  function automatic logic [4:0] cmd_code_of(input logic [7:0] c);
    logic [4:0] r;
    begin
      unique case (c)
        "E": r = 5'd1;  "C": r = 5'd2;  "S": r = 5'd3;  "D": r = 5'd4;
        "a": r = 5'd5;  "d": r = 5'd6;  "L": r = 5'd7;  "l": r = 5'd8;
        "R": r = 5'd9;  "T": r = 5'd10; "e": r = 5'd11; "u": r = 5'd12;
        "I": r = 5'd13; "U": r = 5'd14; "r": r = 5'd15; "h": r = 5'd16;
        "G": r = 5'd17; "g": r = 5'd18;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

  // three-letter opcode to type base (1 + 7*k), zero for unknown
  function automatic logic [5:0] opcode_base(input logic [23:0] p);
    logic [5:0] r;
    begin
      unique case (p)
        "wtp": r = 6'd1;  "cpb": r = 6'd8;  "spb": r = 6'd15; "dob": r = 6'd22;
        "dib": r = 6'd29; "ddr": r = 6'd36; "rps": r = 6'd43; "wps": r = 6'd50;
        default: r = 6'd0;
      endcase
      return r;
    end
  endfunction

endpackage

[sv/scp_front.sv]
module scp_front (
  input  logic              kind,
  input  logic [7:0]        ch,
  output scp_pkg::cls_item_t item
);
  import scp_pkg::*;

  // classify one character
  always_comb begin
    item = '0;
    item.clr = kind;
    item.ch = ch;
    item.cmd_code = cmd_code_of(ch);
    item.cls = CL_OTHER;
    if (ch == "-") begin
      item.cls = CL_DASH;
    end else if (ch == ":") begin
      item.cls = CL_COLON;
    end else if (ch >= "0" && ch <= "9") begin
      item.cls = CL_DEC;
      item.dig = 4'(ch - 8'h30);
    end else if (ch >= "a" && ch <= "f") begin
      item.cls = CL_HEXL;
      item.dig = 4'(ch - 8'h57);
    end else if (ch >= "A" && ch <= "F") begin
      item.cls = CL_HEXL;
      item.dig = 4'(ch - 8'h37);
    end
    if (ch >= "A" && ch <= "G") begin
      item.port = 3'(ch - "A");
    end else if (ch >= "a" && ch <= "g") begin
      item.port = 3'(ch - "a");
    end else begin
      item.port = 3'd7;
    end
  end
endmodule

[sv/scp_queue.sv]
module scp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic         empty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  // hold two entries
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr && !full) - 2'(rd && !empty);
    end
  end
endmodule

[sv/scp_back.sv]
module scp_back #(
  parameter int PROGRAM_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  scp_pkg::cls_item_t item,
  output scp_pkg::result_t   res
);
  import scp_pkg::*;

  logic [4:0]  cmd_r, cmd_nxt;
  logic [3:0]  ph_r, ph_nxt;
  logic [2:0]  dc_r, dc_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  sa_r, sa_nxt;
  logic [15:0] wa_r, wa_nxt;
  logic [6:0]  hr_r, hr_nxt, mi_r, mi_nxt, se_r, se_nxt;
  logic [9:0]  ms_r, ms_nxt;
  logic [5:0]  it_r, it_nxt;
  logic [7:0]  ia_r, ia_nxt;
  logic [7:0]  pf_r [3];
  logic [7:0]  pf_nxt [3];
  logic        ps_r, ps_nxt;
  logic [3:0]  st;
  logic        isdec, ishex;
  logic [2:0]  op;
  logic [23:0] pfx;
  logic [5:0]  base;
  logic [6:0]  t7;
  logic [7:0]  s8;

  assign isdec = item.cls == CL_DEC;
  assign ishex = isdec || item.cls == CL_HEXL;
  // opcode index from type: (type-1)/7 via small compare chain
  always_comb begin
    op = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (it_r >= 6'(1 + 7 * k)) op = 3'(k);
    end
  end
  assign pfx = {pf_r[0], pf_r[1], item.ch};
  assign base = opcode_base(pfx);

  // step the parser by one item
  always_comb begin
    cmd_nxt = cmd_r; ph_nxt = ph_r; dc_nxt = dc_r; done_nxt = done_r;
    sa_nxt = sa_r; wa_nxt = wa_r; hr_nxt = hr_r; mi_nxt = mi_r; se_nxt = se_r;
    ms_nxt = ms_r; it_nxt = it_r; ia_nxt = ia_r; ps_nxt = ps_r;
    pf_nxt = pf_r;
    st = ST_OK;
    t7 = '0;
    s8 = '0;
    if (item.clr || (cmd_r == 5'd0 && item.cmd_code == 5'd0)) begin
      cmd_nxt = '0; ph_nxt = PH_NONE; dc_nxt = '0; done_nxt = 1'b0;
      hr_nxt = '0; mi_nxt = '0; se_nxt = '0; ms_nxt = '0; it_nxt = '0;
      ia_nxt = '0; ps_nxt = 1'b0; pf_nxt = '{default: '0};
      st = item.clr ? ST_OK : ST_UNKNOWN;
    end else if (cmd_r == 5'd0) begin
      cmd_nxt = item.cmd_code;
      if (item.ch == "e") begin
        wa_nxt = '0;
      end else if (item.ch == "g") begin
        ph_nxt = PH_CFG_FIELD; dc_nxt = '0; sa_nxt = '0;
      end else if (item.ch != "S" && item.ch != "R" && item.ch != "T") begin
        done_nxt = 1'b1;
      end
    end else if (cmd_r == CMD_WR_CFG) begin
      if (item.cls == CL_DASH) begin
        if (ph_r == PH_CFG_FIELD && dc_r != 3'd0) begin
          ph_nxt = PH_CFG_VALUE; dc_nxt = '0; wa_nxt = '0;
        end else st = ST_BAD;
      end else if (ph_r == PH_CFG_FIELD) begin
        if (dc_r >= 3'd2) st = ST_CFG;
        else if (!ishex) st = ST_HEX;
        else begin
          sa_nxt = {sa_r[3:0], item.dig}; dc_nxt = dc_r + 3'd1;
        end
      end else if (ph_r == PH_CFG_VALUE) begin
        if (dc_r >= 3'd5) st = ST_CFG;
        else if (!isdec) st = ST_DEC;
        else begin
          wa_nxt = 16'(wa_r * 16'd10 + 16'(item.dig));
          dc_nxt = dc_r + 3'd1; done_nxt = 1'b1;
        end
      end else st = ST_BAD;
    end else if (cmd_r == CMD_DEL_INSTR) begin
      if (item.cls == CL_DASH) begin
        ph_nxt = PH_INUM; dc_nxt = '0;
      end else if (ph_r != PH_INUM) st = ST_BAD;
      else if (dc_r >= 3'd5) st = ST_INUM;
      else if (!isdec) st = ST_DEC;
      else begin
        dc_nxt = dc_r + 3'd1;
        wa_nxt = 16'(wa_r * 16'd10 + 16'(item.dig));
        done_nxt = 1'b1;
      end
    end else if (cmd_r == CMD_SEL_PROG) begin
      if (item.cls == CL_DASH) begin
        ph_nxt = PH_PROG; sa_nxt = '0; dc_nxt = '0;
      end else if (ph_r != PH_PROG || dc_r >= 3'd2) st = ST_BAD;
      else if (!isdec) st = ST_DEC;
      else begin
        dc_nxt = dc_r + 3'd1;
        s8 = 8'(sa_r * 8'd10 + 8'(item.dig));
        sa_nxt = s8;
        if (32'(s8) < PROGRAM_COUNT) done_nxt = 1'b1;
      end
    end else if (cmd_r == CMD_TIME_A || cmd_r == CMD_TIME_B) begin
      if (item.cls == CL_DASH) begin
        if (ph_r == PH_NONE) begin
          ph_nxt = PH_HOUR; hr_nxt = '0; dc_nxt = '0;
        end else if (ph_r == PH_MSEC) begin
          ph_nxt = PH_OPCODE; it_nxt = '0; ia_nxt = '0; dc_nxt = '0;
        end else if (ph_r == PH_PORT && it_r != 6'd0 && (op == 3'd0 || op >= 3'd5)) begin
          ph_nxt = PH_HEX; ia_nxt = '0; dc_nxt = '0;
        end else st = ST_BAD;
      end else if (item.cls == CL_COLON) begin
        dc_nxt = '0;
        if (ph_r == PH_HOUR) begin
          ph_nxt = PH_MIN; mi_nxt = '0;
        end else if (ph_r == PH_MIN) begin
          ph_nxt = PH_SEC; se_nxt = '0;
        end else if (ph_r == PH_SEC) begin
          ph_nxt = PH_MSEC; ms_nxt = '0;
        end else begin
          st = ST_BAD; dc_nxt = dc_r;
        end
      end else begin
        case (ph_r)
          PH_HEX: begin
            if (dc_r >= 3'd2) st = ST_BAD;
            else if (!ishex) st = ST_HEX;
            else begin
              dc_nxt = dc_r + 3'd1; ia_nxt = {ia_r[3:0], item.dig}; done_nxt = 1'b1;
            end
          end
          PH_HOUR, PH_MIN, PH_SEC: begin
            if (dc_r >= 3'd2) st = ST_BAD;
            else if (!isdec) st = ST_DEC;
            else begin
              dc_nxt = dc_r + 3'd1;
              if (ph_r == PH_HOUR) begin
                hr_nxt = 7'(hr_r * 7'd10 + 7'(item.dig));
              end else if (ph_r == PH_MIN) begin
                t7 = 7'(mi_r * 7'd10 + 7'(item.dig));
                mi_nxt = t7;
                if (t7 >= TIME_LIMIT) st = ST_MIN;
              end else begin
                t7 = 7'(se_r * 7'd10 + 7'(item.dig));
                se_nxt = t7;
                if (t7 >= TIME_LIMIT) st = ST_SEC;
              end
            end
          end
          PH_MSEC: begin
            if (dc_r >= 3'd3) st = ST_BAD;
            else if (!isdec) st = ST_DEC;
            else begin
              dc_nxt = dc_r + 3'd1;
              ms_nxt = 10'(ms_r * 10'd10 + 10'(item.dig));
            end
          end
          PH_OPCODE: begin
            if (dc_r >= 3'd3) st = ST_PREFIX;
            else begin
              pf_nxt[dc_r[1:0]] = item.ch;
              dc_nxt = dc_r + 3'd1;
              if (dc_r == 3'd2) begin
                if (base != 6'd0) begin
                  it_nxt = base; ia_nxt = '0; ph_nxt = PH_PORT;
                  dc_nxt = '0; ps_nxt = 1'b0;
                end else st = ST_PREFIX;
              end
            end
          end
          PH_PORT: begin
            if (ps_r || it_r == 6'd0 || item.port == 3'd7) st = ST_PORT;
            else begin
              it_nxt = it_r + 6'(item.port);
              ps_nxt = 1'b1;
              if (op >= 3'd1 && op <= 3'd4) begin
                ph_nxt = (item.port == 3'd6) ? PH_GBIT : PH_BIT;
              end
            end
          end
          PH_BIT, PH_GBIT: begin
            if (item.ch >= "0" && (item.ch <= "4" ||
                (ph_r == PH_BIT && item.ch <= "7"))) begin
              ia_nxt = item.ch - 8'h30; done_nxt = 1'b1;
            end else st = ST_BIT;
          end
          default: st = ST_BAD;
        endcase
      end
    end else begin
      st = ST_BAD;
    end
  end

  // commit state on each item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0; ph_r <= PH_NONE; dc_r <= '0; done_r <= 1'b0; sa_r <= '0;
      wa_r <= '0; hr_r <= '0; mi_r <= '0; se_r <= '0; ms_r <= '0; it_r <= '0;
      ia_r <= '0; ps_r <= 1'b0; pf_r <= '{default: '0};
    end else if (go) begin
      cmd_r <= cmd_nxt; ph_r <= ph_nxt; dc_r <= dc_nxt; done_r <= done_nxt;
      sa_r <= sa_nxt; wa_r <= wa_nxt; hr_r <= hr_nxt; mi_r <= mi_nxt;
      se_r <= se_nxt; ms_r <= ms_nxt; it_r <= it_nxt; ia_r <= ia_nxt;
      ps_r <= ps_nxt; pf_r <= pf_nxt;
    end
  end

  always_comb begin
    res.status = st; res.done = done_nxt; res.command = cmd_nxt;
    res.phase = ph_nxt; res.small_arg = sa_nxt; res.wide_arg = wa_nxt;
    res.hour = hr_nxt; res.minute = mi_nxt; res.second = se_nxt;
    res.msec = ms_nxt; res.instr_type = it_nxt; res.instr_arg = ia_nxt;
  end
endmodule

[sv/sequencer_command_parser.sv]
// Command parser: one character item per cycle, back to back, when not full.
// Each item is registered in the mid queue, then the back end steps it into
// the result queue. Throughput: one item per cycle while the result queue has
// room; the back end commits its whole state update on each step.
// Reset (rst_n low, synchronous) clears all parser state and both queues.
module sequencer_command_parser #(
  parameter int PROGRAM_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [7:0]  in_char_in,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_status,
  output logic        out_done_res,
  output logic [4:0]  out_command,
  output logic [3:0]  out_phase,
  output logic [7:0]  out_small_arg,
  output logic [15:0] out_wide_arg,
  output logic [6:0]  out_hour,
  output logic [6:0]  out_minute,
  output logic [6:0]  out_second,
  output logic [9:0]  out_millisecond,
  output logic [5:0]  out_instr_type,
  output logic [7:0]  out_instr_arg
);
  import scp_pkg::*;
  `include "assert_macros.svh"

  cls_item_t fi, bi;
  result_t   res, outr;
  logic      mid_empty, res_full, go;

  scp_front u_front (.kind(in_kind), .ch(in_char_in), .item(fi));

  scp_queue #(.W($bits(cls_item_t))) u_midq (
    .clk(clk), .rst_n(rst_n), .wr(push), .wdata(fi), .full(full),
    .rd(go), .empty(mid_empty), .rdata(bi)
  );

  // advance the back end when an item waits and the result queue has room
  assign go = !mid_empty && !res_full;

  scp_back #(.PROGRAM_COUNT(PROGRAM_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .go(go), .item(bi), .res(res)
  );

  scp_queue #(.W($bits(result_t))) u_outq (
    .clk(clk), .rst_n(rst_n), .wr(go), .wdata(res), .full(res_full),
    .rd(pop), .empty(empty), .rdata(outr)
  );

  assign out_status = outr.status;
  assign out_done_res = outr.done;
  assign out_command = outr.command;
  assign out_phase = outr.phase;
  assign out_small_arg = outr.small_arg;
  assign out_wide_arg = outr.wide_arg;
  assign out_hour = outr.hour;
  assign out_minute = outr.minute;
  assign out_second = outr.second;
  assign out_millisecond = outr.msec;
  assign out_instr_type = outr.instr_type;
  assign out_instr_arg = outr.instr_arg;

  `CHK_IMPLY(a_go_needs_room, go, !res_full)
  `CHK_NEXT(a_push_fills, push && !full && mid_empty && !go, !mid_empty)
  `CHK_IMPLY(a_status_range, !empty, out_status <= ST_BIT)
endmodule

[test/sequencer_command_parser_tb.sv]
`timescale 1ns / 1ps

module sequencer_command_parser_tb;
  import scp_pkg::*;

  localparam int NO_CHECK = -1;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_START = 1500;
  localparam int HOLD_LEN = 300;
  localparam int PROG_COUNT = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_kind = 1'b0;
  logic [7:0]  in_char_in = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  out_status;
  logic        out_done_res;
  logic [4:0]  out_command;
  logic [3:0]  out_phase;
  logic [7:0]  out_small_arg;
  logic [15:0] out_wide_arg;
  logic [6:0]  out_hour;
  logic [6:0]  out_minute;
  logic [6:0]  out_second;
  logic [9:0]  out_millisecond;
  logic [5:0]  out_instr_type;
  logic [7:0]  out_instr_arg;

  sequencer_command_parser #(.PROGRAM_COUNT(PROG_COUNT)) dut (.*);

  always #1 clk = ~clk;

  // parser state mirror
  logic [4:0]  m_cmd = '0;
  logic [3:0]  m_phase = PH_NONE;
  logic [2:0]  m_cnt = '0;
  logic        m_done = 1'b0;
  logic [7:0]  m_small = '0;
  logic [15:0] m_wide = '0;
  logic [6:0]  m_hour = '0, m_min = '0, m_sec = '0;
  logic [9:0]  m_msec = '0;
  logic [5:0]  m_type = '0;
  logic [7:0]  m_iarg = '0;
  logic [7:0]  m_pre [3] = '{8'h00, 8'h00, 8'h00};
  logic        m_port_seen = 1'b0;

  string cmd_letters = "ECSDadLlRTeuIUrhGg";
  string opcode_names [8] = '{"wtp", "cpb", "spb", "dob", "dib", "ddr", "rps", "wps"};

  result_t expected_q [$];
  int      table_status_q [$];
  int      pending_table_q [$];
  int      errors = 0;
  int      accepted = 0;
  int      checked = 0;
  int      time_cmds = 0;

  function automatic int digit_val(logic [7:0] c, bit hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void clear_parser();
    m_pre = '{8'h00, 8'h00, 8'h00};
    m_done = 1'b0; m_cmd = '0; m_phase = PH_NONE; m_cnt = '0;
    m_iarg = '0; m_hour = '0; m_msec = '0; m_min = '0; m_sec = '0;
    m_type = '0; m_port_seen = 1'b0;
  endfunction

  // leading letter of a command
  function automatic logic [3:0] start_cmd(logic [7:0] c);
    int i;
    for (i = 0; i < 18; i++)
      if (cmd_letters[i] == c) break;
    if (i == 18) begin
      clear_parser();
      return ST_UNKNOWN;
    end
    m_cmd = 5'(i + 1);
    if (c == "S" || c == "R" || c == "T") return ST_OK;
    if (c == "e") begin
      m_wide = '0;
      return ST_OK;
    end
    if (c == "g") begin
      m_phase = PH_CFG_FIELD; m_cnt = '0; m_small = '0;
      return ST_OK;
    end
    m_done = 1'b1;
    return ST_OK;
  endfunction

  // time instruction characters
  function automatic logic [3:0] time_cmd(logic [7:0] c);
    int d, op, p, k;
    if (c == "-") begin
      if (m_phase == PH_NONE) begin
        m_phase = PH_HOUR; m_hour = '0; m_cnt = '0;
      end else if (m_phase == PH_MSEC) begin
        m_phase = PH_OPCODE; m_type = '0; m_iarg = '0; m_cnt = '0;
      end else if (m_phase == PH_PORT && m_type != 0) begin
        op = (m_type - 1) / 7;
        if (op == 0 || op >= 5) begin
          m_phase = PH_HEX; m_iarg = '0; m_cnt = '0;
        end else return ST_BAD;
      end else return ST_BAD;
      return ST_OK;
    end
    if (c == ":") begin
      if (m_phase == PH_HOUR) begin
        m_phase = PH_MIN; m_min = '0;
      end else if (m_phase == PH_MIN) begin
        m_phase = PH_SEC; m_sec = '0;
      end else if (m_phase == PH_SEC) begin
        m_phase = PH_MSEC; m_msec = '0;
      end else return ST_BAD;
      m_cnt = '0;
      return ST_OK;
    end
    case (m_phase)
      PH_HEX: begin
        if (m_cnt >= 2) return ST_BAD;
        d = digit_val(c, 1'b1);
        if (d < 0) return ST_HEX;
        m_cnt++;
        m_iarg = 8'(m_iarg * 16 + d);
        m_done = 1'b1;
        return ST_OK;
      end
      PH_HOUR, PH_MIN, PH_SEC: begin
        if (m_cnt >= 2) return ST_BAD;
        d = digit_val(c, 1'b0);
        if (d < 0) return ST_DEC;
        m_cnt++;
        if (m_phase == PH_HOUR) begin
          m_hour = 7'(m_hour * 10 + d);
          return ST_OK;
        end
        if (m_phase == PH_MIN) begin
          m_min = 7'(m_min * 10 + d);
          return (m_min >= TIME_LIMIT) ? ST_MIN : ST_OK;
        end
        m_sec = 7'(m_sec * 10 + d);
        return (m_sec >= TIME_LIMIT) ? ST_SEC : ST_OK;
      end
      PH_MSEC: begin
        if (m_cnt >= 3) return ST_BAD;
        d = digit_val(c, 1'b0);
        if (d < 0) return ST_DEC;
        m_cnt++;
        m_msec = 10'(m_msec * 10 + d);
        return ST_OK;
      end
      PH_OPCODE: begin
        if (m_cnt >= 3) return ST_PREFIX;
        m_pre[m_cnt[1:0]] = c;
        m_cnt++;
        if (m_cnt < 3) return ST_OK;
        for (k = 0; k < 8; k++)
          if (m_pre[0] == opcode_names[k][0] && m_pre[1] == opcode_names[k][1] &&
              m_pre[2] == opcode_names[k][2]) begin
            m_type = 6'(1 + 7 * k);
            m_iarg = '0; m_phase = PH_PORT; m_cnt = '0; m_port_seen = 1'b0;
            return ST_OK;
          end
        return ST_PREFIX;
      end
      PH_PORT: begin
        if (m_port_seen || m_type == 0) return ST_PORT;
        if (c >= "A" && c <= "G") p = c - "A";
        else if (c >= "a" && c <= "g") p = c - "a";
        else return ST_PORT;
        op = (m_type - 1) / 7;
        m_type = 6'(m_type + p);
        m_port_seen = 1'b1;
        if (op >= 1 && op <= 4) m_phase = (p == 6) ? PH_GBIT : PH_BIT;
        return ST_OK;
      end
      PH_BIT, PH_GBIT: begin
        if (c >= "0" && (c <= "4" || (m_phase == PH_BIT && c <= "7"))) begin
          m_iarg = 8'(c - "0");
          m_done = 1'b1;
          return ST_OK;
        end
        return ST_BIT;
      end
      default: return ST_BAD;
    endcase
  endfunction

  function automatic logic [3:0] parse_cmd(logic [7:0] c);
    int d;
    case (m_cmd)
      5'd0: return start_cmd(c);
      CMD_WR_CFG: begin
        if (c == "-") begin
          if (m_phase == PH_CFG_FIELD && m_cnt > 0) begin
            m_phase = PH_CFG_VALUE; m_cnt = '0; m_wide = '0;
            return ST_OK;
          end
          return ST_BAD;
        end
        if (m_phase == PH_CFG_FIELD) begin
          if (m_cnt >= 2) return ST_CFG;
          d = digit_val(c, 1'b1);
          if (d < 0) return ST_HEX;
          m_small = 8'(m_small * 16 + d);
          m_cnt++;
          return ST_OK;
        end
        if (m_phase == PH_CFG_VALUE) begin
          if (m_cnt >= 5) return ST_CFG;
          d = digit_val(c, 1'b0);
          if (d < 0) return ST_DEC;
          m_wide = 16'(m_wide * 10 + d);
          m_cnt++;
          m_done = 1'b1;
          return ST_OK;
        end
        return ST_BAD;
      end
      CMD_DEL_INSTR: begin
        if (c == "-") begin
          m_phase = PH_INUM; m_cnt = '0;
          return ST_OK;
        end
        if (m_phase != PH_INUM) return ST_BAD;
        if (m_cnt >= 5) return ST_INUM;
        d = digit_val(c, 1'b0);
        if (d < 0) return ST_DEC;
        m_cnt++;
        m_wide = 16'(m_wide * 10 + d);
        m_done = 1'b1;
        return ST_OK;
      end
      CMD_SEL_PROG: begin
        if (c == "-") begin
          m_phase = PH_PROG; m_small = '0; m_cnt = '0;
          return ST_OK;
        end
        if (m_phase != PH_PROG || m_cnt >= 2) return ST_BAD;
        d = digit_val(c, 1'b0);
        if (d < 0) return ST_DEC;
        m_cnt++;
        m_small = 8'(m_small * 10 + d);
        if (m_small < PROG_COUNT) m_done = 1'b1;
        return ST_OK;
      end
      CMD_TIME_A, CMD_TIME_B: return time_cmd(c);
      default: return ST_BAD;
    endcase
  endfunction

  // advance the mirror by one item and return the result it yields
  function automatic result_t parser_step(logic k, logic [7:0] c);
    result_t r;
    r.status = ST_OK;
    if (k) clear_parser();
    else r.status = parse_cmd(c);
    r.done = m_done; r.command = m_cmd; r.phase = m_phase;
    r.small_arg = m_small; r.wide_arg = m_wide;
    r.hour = m_hour; r.minute = m_min; r.second = m_sec; r.msec = m_msec;
    r.instr_type = m_type; r.instr_arg = m_iarg;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // record accepted items, check accepted results
  always @(posedge clk) begin
    result_t e;
    int      t;
    if (rst_n) begin
      if (push && !full) begin
        expected_q.push_back(parser_step(in_kind, in_char_in));
        pending_table_q.push_back(table_status_q.pop_front());
        accepted++;
      end
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          t = pending_table_q.pop_front();
          if (t != NO_CHECK) check_field("status (table)", t, out_status);
          check_field("status", e.status, out_status);
          check_field("done_res", e.done, out_done_res);
          check_field("command", e.command, out_command);
          check_field("phase", e.phase, out_phase);
          check_field("small_arg", e.small_arg, out_small_arg);
          check_field("wide_arg", e.wide_arg, out_wide_arg);
          check_field("hour", e.hour, out_hour);
          check_field("minute", e.minute, out_minute);
          check_field("second", e.second, out_second);
          check_field("millisecond", e.msec, out_millisecond);
          check_field("instr_type", e.instr_type, out_instr_type);
          check_field("instr_arg", e.instr_arg, out_instr_arg);
          checked++;
        end
      end
    end
  end

  // receiver: stall pattern redrawn at random among four modes, one long hold
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_START) begin
        pop <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ((cyc / 8) % 2 == 0);
        endcase
      end
    end
  end

  // sender
  int      burst_left = 1;
  logic [7:0] char_seq [$];

  task automatic send_item(logic k, logic [7:0] c, int table_st);
    push <= 1'b1;
    in_kind <= k;
    in_char_in <= c;
    table_status_q.push_back(table_st);
    do @(posedge clk); while (full);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // stop sending, let the last accepted item be recorded, then wait for all results
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic void add_digits(int lo, int hi, bit hex);
    string hexset;
    string decset;
    int n;
    hexset = "0123456789abcdefABCDEF";
    decset = "0123456789";
    n = $urandom_range(lo, hi);
    repeat (n)
      if (hex) char_seq.push_back(hexset[$urandom_range(0, 21)]);
      else char_seq.push_back(decset[$urandom_range(0, 9)]);
  endfunction

  // build one well-formed-ish command with random content
  function automatic void build_command();
    string portset;
    int sel;
    int op;
    portset = "ABCDEFGabcdefg";
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        char_seq.push_back("g"); add_digits(1, 3, 1'b1);
        char_seq.push_back("-"); add_digits(1, 6, 1'b0);
      end
      1: begin
        char_seq.push_back("S"); char_seq.push_back("-"); add_digits(1, 3, 1'b0);
      end
      2: begin
        char_seq.push_back("e"); char_seq.push_back("-"); add_digits(1, 6, 1'b0);
      end
      3: begin
        char_seq.push_back(cmd_letters[$urandom_range(0, 17)]);
        add_digits(0, 2, 1'b1);
      end
      default: begin
        char_seq.push_back($urandom_range(0, 1) ? "R" : "T");
        char_seq.push_back("-"); add_digits(1, 3, 1'b0);
        char_seq.push_back(":"); add_digits(1, 3, 1'b0);
        char_seq.push_back(":"); add_digits(1, 3, 1'b0);
        char_seq.push_back(":"); add_digits(1, 4, 1'b0);
        char_seq.push_back("-");
        op = $urandom_range(0, 8);
        if (op == 8) begin
          repeat ($urandom_range(1, 4)) char_seq.push_back(8'($urandom_range(8'h61, 8'h7a)));
        end else begin
          char_seq.push_back(opcode_names[op][0]);
          char_seq.push_back(opcode_names[op][1]);
          char_seq.push_back(opcode_names[op][2]);
        end
        if ($urandom_range(0, 7) != 0) char_seq.push_back(portset[$urandom_range(0, 13)]);
        if ($urandom_range(0, 7) == 0) char_seq.push_back(portset[$urandom_range(0, 13)]);
        if ($urandom_range(0, 1)) begin
          char_seq.push_back("-"); add_digits(1, 3, 1'b1);
        end else begin
          add_digits(1, 2, 1'b0);
        end
      end
    endcase
  endfunction

  typedef struct {
    logic       k;
    logic [7:0] c;
    int         st;
  } dir_row_t;

  dir_row_t dir_rows [25] = '{
    '{1'b0, 8'h00, ST_UNKNOWN}, '{1'b0, 8'hFF, ST_UNKNOWN}, '{1'b0, "S", ST_OK},
    '{1'b0, "7", ST_BAD}, '{1'b0, "-", NO_CHECK}, '{1'b0, "1", NO_CHECK},
    '{1'b0, "5", NO_CHECK}, '{1'b0, "9", ST_BAD}, '{1'b1, 8'hFF, ST_OK},
    '{1'b0, "g", ST_OK}, '{1'b0, "x", ST_HEX}, '{1'b0, "F", NO_CHECK},
    '{1'b0, "f", NO_CHECK}, '{1'b0, "0", ST_CFG}, '{1'b0, "-", NO_CHECK},
    '{1'b0, "9", NO_CHECK}, '{1'b0, "9", NO_CHECK}, '{1'b0, "9", NO_CHECK},
    '{1'b0, "9", NO_CHECK}, '{1'b0, "9", NO_CHECK}, '{1'b0, "9", ST_CFG},
    '{1'b1, 8'h00, ST_OK}, '{1'b0, "T", ST_OK}, '{1'b0, "-", NO_CHECK},
    '{1'b0, ":", NO_CHECK}
  };

  initial begin
    int sent;
    int drain;
    logic [7:0] ch;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) send_item(dir_rows[i].k, dir_rows[i].c, dir_rows[i].st);
    wait_drained();

    // random commands, most started from a cleared parser, with noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) char_seq.push_back(8'($urandom_range(0, 255)));
      else if ($urandom_range(0, 1)) char_seq.push_back("z");
      build_command();
      if (char_seq.size() > 6 && (char_seq[0] == "R" || char_seq[0] == "T")) time_cmds++;
      if ($urandom_range(0, 4) != 0) send_item(1'b1, 8'($urandom_range(0, 255)), NO_CHECK);
      else send_item(1'b0, "z", NO_CHECK);
      sent++;
      while (char_seq.size() != 0) begin
        ch = char_seq.pop_front();
        if ($urandom_range(0, 29) == 0) ch = 8'($urandom_range(0, 255));
        send_item(1'b0, ch, NO_CHECK);
        sent++;
        if ($urandom_range(0, 59) == 0) begin
          send_item(1'b0, 8'($urandom_range(0, 255)), NO_CHECK);
          sent++;
        end
      end
      if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 20) wait_drained();
    end

    // let the pipeline empty out
    push <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (expected_q.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      errors++;
    end
    $display("Covered %0d parser items (%0d checked), %0d time instruction commands,",
             accepted, checked, time_cmds);
    $display("with directed extremes, random noise and a long receiver hold.");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
